### sv/mi_pkg.sv
`timescale 1ns / 1ps
// modular inverse package: controller states and the command and status
// structs between controller and datapath; no dependencies
package mi_pkg;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RED   = 8'b0000_0010,
        ST_RFIX  = 8'b0000_0100,
        ST_TEST  = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_UPD   = 8'b0010_0000,
        ST_FIN   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load;       // capture a new transaction
        logic step;       // one restoring-division step
        logic red_done;   // finish the reduction, set up euclid
        logic euc_start;  // start dividing b by a
        logic euc_update; // shift remainders and coefficients
        logic finish;     // form the result
    } cmd_t;

    typedef struct packed {
        logic m_zero;
        logic a_zero;
        logic div_last;
    } status_t;

endpackage

### sv/mi_in_if.sv
`timescale 1ns / 1ps
// input channel of the modular inverse: valid, ready, value and modulus
// no dependencies
interface mi_in_if #(parameter int DATA_WIDTH = 64);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-2:0] modulus;

    modport source (output valid, value, modulus, input ready);
    modport sink   (input valid, value, modulus, output ready);
endinterface

### sv/mi_out_if.sv
`timescale 1ns / 1ps
// result channel of the modular inverse: valid, ready, inverse and flag
// no dependencies
interface mi_out_if #(parameter int DATA_WIDTH = 64);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-2:0] inverse;
    logic                  not_invertible;

    modport source (output valid, inverse, not_invertible, input ready);
    modport sink   (input valid, inverse, not_invertible, output ready);
endinterface

### sv/modular_inverse.sv
`timescale 1ns / 1ps
// modular inverse top level: controller plus datapath
// depends on mi_pkg, mi_in_if, mi_out_if, mi_controller, mi_datapath
//
// usage:
//   in_ch carries value (signed) and modulus; out_ch returns inverse in
//   0 .. modulus-1 and not_invertible, raised with inverse 0 when the gcd
//   of value and modulus is not 1 (modulus 0 counts as not invertible).
//   one transaction is processed at a time; in_ch.ready is high only while
//   the block is idle.
//   the reduction runs through ST_RED and ST_RFIX, each euclid quotient
//   through ST_TEST, ST_DIV and ST_UPD, and the result is formed in ST_FIN;
//   the serial restoring divider does both, one quotient bit per cycle.
//   a new transaction is taken only once the previous result has been taken.
//   reset clears the sequencer; no result is pending after reset.
//   a stalled receiver holds the result in the output register and the
//   block takes no new transaction until it is taken.
module modular_inverse #(
    parameter int DATA_WIDTH = 64
) (
    input logic clk,
    input logic rst_n,
    mi_in_if.sink    in_ch,
    mi_out_if.source out_ch
);
    import mi_pkg::*;

    cmd_t    cmd;
    status_t status;

    mi_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mi_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .value          (in_ch.value),
        .modulus        (in_ch.modulus),
        .inverse        (out_ch.inverse),
        .not_invertible (out_ch.not_invertible)
    );

endmodule

### sv/mi_datapath.sv
`timescale 1ns / 1ps
// modular inverse datapath: serial restoring divider with a shift-add
// quotient times coefficient accumulator; depends on mi_pkg
module mi_datapath #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mi_pkg::cmd_t          cmd,
    output mi_pkg::status_t       status,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-2:0] modulus,
    output logic [DATA_WIDTH-2:0] inverse,
    output logic                  not_invertible
);
    import mi_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);
    localparam int DW = DATA_WIDTH;

    logic [DW-2:0] m_reg, m_next;
    logic          neg_reg, neg_next;
    logic [DW-2:0] a_reg, a_next, b_reg, b_next;
    logic [DW-1:0] cu_reg, cu_next, cv_reg, cv_next, acc_reg, acc_next;
    logic          uneg_reg, uneg_next, vneg_reg, vneg_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [DW-2:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-2:0] inv_reg, inv_next;
    logic          ni_reg, ni_next;

    logic [DW-1:0] rem_t, rem_sub, mag, cfix, m_ext;
    logic          ge;
    logic [DW-2:0] red_r;

    always_comb
    begin
        m_ext   = {1'b0, m_reg};
        rem_t   = {rem_reg, dvd_reg[DW-1]};
        ge      = rem_t >= {1'b0, a_reg};
        rem_sub = rem_t - {1'b0, a_reg};
        mag     = value[DW-1] ? (~value + {{(DW-1){1'b0}}, 1'b1}) : value;
        red_r   = (neg_reg && rem_reg != '0) ? (m_reg - rem_reg) : rem_reg;
        cfix    = (cu_reg >= m_ext) ? (cu_reg - m_ext) : cu_reg;
        if (uneg_reg && cfix != '0)
            cfix = m_ext - cfix;

        m_next    = m_reg;
        neg_next  = neg_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cu_next   = cu_reg;
        cv_next   = cv_reg;
        acc_next  = acc_reg;
        uneg_next = uneg_reg;
        vneg_next = vneg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        inv_next  = inv_reg;
        ni_next   = ni_reg;

        if (cmd.load)
        begin
            m_next   = modulus;
            neg_next = value[DW-1];
            a_next   = modulus;          // divisor during the reduction
            dvd_next = mag;
            rem_next = '0;
            acc_next = '0;
            cnt_next = '0;
        end
        if (cmd.step)
        begin
            rem_next = ge ? rem_sub[DW-2:0] : rem_t[DW-2:0];
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            acc_next = {acc_reg[DW-2:0], 1'b0} + (ge ? cv_reg : '0);
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.red_done)
        begin
            a_next    = red_r;
            b_next    = m_reg;
            cu_next   = '0;
            cv_next   = {{(DW-1){1'b0}}, 1'b1};
            uneg_next = 1'b0;
            vneg_next = 1'b0;
        end
        if (cmd.euc_start)
        begin
            dvd_next = {1'b0, b_reg};
            rem_next = '0;
            acc_next = '0;
            cnt_next = '0;
        end
        if (cmd.euc_update)
        begin
            b_next    = a_reg;
            a_next    = rem_reg;
            cu_next   = cv_reg;
            uneg_next = vneg_reg;
            cv_next   = cu_reg + acc_reg;
            vneg_next = !vneg_reg;
        end
        if (cmd.finish)
        begin
            if (m_reg == '0 || b_reg != {{(DW-2){1'b0}}, 1'b1})
            begin
                inv_next = '0;
                ni_next  = 1'b1;
            end
            else
            begin
                inv_next = cfix[DW-2:0];
                ni_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        neg_reg  <= neg_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        cu_reg   <= cu_next;
        cv_reg   <= cv_next;
        acc_reg  <= acc_next;
        uneg_reg <= uneg_next;
        vneg_reg <= vneg_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        inv_reg  <= inv_next;
        ni_reg   <= ni_next;
    end

    assign status.m_zero   = (m_reg == '0);
    assign status.a_zero   = (a_reg == '0);
    assign status.div_last = (cnt_reg == CW'(DW - 1));
    assign inverse         = inv_reg;
    assign not_invertible  = ni_reg;

endmodule

### sv/mi_controller.sv
`timescale 1ns / 1ps
// modular inverse controller: one-hot sequencer over reduction, euclid
// iterations and result delivery; depends on mi_pkg
module mi_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  mi_pkg::status_t status,
    output mi_pkg::cmd_t    cmd
);
    import mi_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RED;
                end
            ST_RED:
                if (status.m_zero)
                    state_next = ST_FIN;
                else
                begin
                    cmd.step = 1'b1;
                    if (status.div_last)
                        state_next = ST_RFIX;
                end
            ST_RFIX:
            begin
                cmd.red_done = 1'b1;
                state_next   = ST_TEST;
            end
            ST_TEST:
                if (status.a_zero)
                    state_next = ST_FIN;
                else
                begin
                    cmd.euc_start = 1'b1;
                    state_next    = ST_DIV;
                end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.euc_update = 1'b1;
                state_next     = ST_TEST;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);

endmodule

### sv/mi_checker.sv
`timescale 1ns / 1ps
// port-level checker for the modular inverse, bound to the top level
// depends on modular_inverse
module mi_checker #(
    parameter int DATA_WIDTH = 64
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-2:0] inverse,
    input logic                  not_invertible
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inverse))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while a result is pending");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_invertible |-> inverse == '0)
        else $error("not invertible result with nonzero inverse");

    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready && !out_valid)
        else $error("block not idle after result transaction");

endmodule

bind modular_inverse mi_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .inverse        (out_ch.inverse),
    .not_invertible (out_ch.not_invertible)
);

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench for modular_inverse (depends on it, mi_in_if, mi_out_if): directed
// and random transactions, a local inverse predictor and in-order result check
module testbench;

    typedef struct {
        logic [63:0] value;
        logic [62:0] modulus;
        bit          drain;     // wait for all results before offering this one
    } operand_t;

    typedef struct {
        logic [62:0] inverse;
        logic        not_invertible;
    } answer_t;

    logic clk;
    logic rst_n;

    mi_in_if  #(.DATA_WIDTH(64)) in_ch();
    mi_out_if #(.DATA_WIDTH(64)) out_ch();

    modular_inverse #(.DATA_WIDTH(64)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    operand_t operand_q[$];
    answer_t  answer_q[$];
    int       errors;
    int       accepted;
    int       total_items;
    bit       in_fire;
    bit       hold_results;
    int       send_idle;
    int       recv_idle;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // extended euclid with coefficient magnitude plus sign
    function automatic answer_t inverse_of(logic [63:0] v, logic [62:0] mod);
        bit [63:0] m, a, b, cu, cv, t, nr, ncv, mag, r;
        bit        u_neg, v_neg;
        answer_t   res;
        m = {1'b0, mod};
        res.inverse = '0;
        res.not_invertible = 1'b1;
        if (m == 64'd0)
            return res;
        if (!v[63])
            a = v % m;
        else
        begin
            mag = ~v + 64'd1;
            r = mag % m;
            a = (r == 64'd0) ? 64'd0 : m - r;
        end
        b = m;
        cu = 64'd0;
        u_neg = 1'b0;
        cv = 64'd1;
        v_neg = 1'b0;
        while (a != 64'd0)
        begin
            t = b / a;
            nr = b - t * a;
            ncv = cu + t * cv;
            b = a;
            a = nr;
            cu = cv;
            u_neg = v_neg;
            cv = ncv;
            v_neg = !v_neg;
        end
        if (b != 64'd1)
            return res;
        if (cu >= m)
            cu = cu % m;
        if (u_neg && cu != 64'd0)
            cu = m - cu;
        res.inverse = cu[62:0];
        res.not_invertible = 1'b0;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_item(logic [63:0] v, logic [62:0] m, bit drain = 1'b0);
        operand_t op;
        op.value = v;
        op.modulus = m;
        op.drain = drain;
        operand_q.push_back(op);
    endtask

    // input driver
    always @(negedge clk)
    begin
        logic nv;
        nv = in_ch.valid;
        if (rst_n && (!in_ch.valid || in_fire))
        begin
            nv = 1'b0;
            if (send_idle > 0)
                send_idle <= send_idle - 1;
            else if (operand_q.size() > 0 &&
                     (!operand_q[0].drain || answer_q.size() == 0))
            begin
                operand_t op;
                op = operand_q.pop_front();
                in_ch.value <= op.value;
                in_ch.modulus <= op.modulus;
                nv = 1'b1;
                if (operand_q.size() > 150 && $urandom_range(0, 5) == 0)
                    send_idle <= $urandom_range(1, 4);
            end
        end
        in_ch.valid <= nv;
    end

    // result ready, with random stalls and the long hold-off
    always @(negedge clk)
    begin
        if (recv_idle > 0)
            recv_idle <= recv_idle - 1;
        else if (operand_q.size() > 150 && $urandom_range(0, 4) == 0)
            recv_idle <= $urandom_range(1, 4);
        out_ch.ready <= rst_n && !hold_results && recv_idle == 0;
    end

    // accept inputs, predict, and check results
    always @(posedge clk)
    begin
        answer_t want;
        in_fire <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            answer_q.push_back(inverse_of(in_ch.value, in_ch.modulus));
            accepted <= accepted + 1;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (answer_q.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (out_ch.inverse !== want.inverse)
                begin
                    $error("inverse: expected %0d, got %0d", want.inverse, out_ch.inverse);
                    errors++;
                end
                if (out_ch.not_invertible !== want.not_invertible)
                begin
                    $error("not_invertible: expected %0b, got %0b",
                           want.not_invertible, out_ch.not_invertible);
                    errors++;
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        hold_results = 1'b0;
        wait (accepted >= 300);
        hold_results = 1'b1;
        repeat (500) @(posedge clk);
        hold_results = 1'b0;
    end

    initial
    begin
        #200_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [62:0] m;
        logic [63:0] v;
        errors = 0;
        accepted = 0;
        in_fire = 0;
        send_idle = 0;
        recv_idle = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.modulus = '0;
        out_ch.ready = 1'b0;

        // modulus one, zero value, common factor, modulus zero, extremes
        add_item(64'd5, 63'd1);
        add_item(64'h8000_0000_0000_0000, 63'd1);
        add_item(64'd0, 63'd7);
        add_item(64'd6, 63'd9);
        add_item(64'd3, 63'd0);
        add_item(64'd1, 63'd2);
        add_item(64'd3, 63'd7);
        add_item(-64'sd3, 63'd7);
        add_item(-64'sd1, 63'h7FFF_FFFF_FFFF_FFFF);
        add_item(64'h8000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF);
        add_item(64'h8000_0000_0000_0000, 63'd3);
        add_item(64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFE);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 63'd0);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
        // consecutive fibonacci numbers give the most quotients
        add_item(64'd4660046610375530309, 63'd7540113804746346429);
        add_item(64'd12, 63'd18);
        add_item(64'd10, 63'd1000000007, 1'b1);

        total_items = 1700;
        for (int i = 0; i < total_items; i++)
        begin
            case ($urandom_range(0, 19))
                0:       m = 63'd1;
                1:       m = 63'd0;
                2, 3:    m = 63'(rand64());
                4, 5:    m = 63'(rand64() >> $urandom_range(1, 62));
                default: m = 63'($urandom_range(2, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       v = rand64();
                1:       v = 64'($urandom_range(0, 1000));
                2:       v = -$signed({32'd0, $urandom_range(0, 100000)});
                default: v = {1'b0, m} * $urandom_range(0, 3) + $urandom_range(0, 1);
            endcase
            add_item(v, m, (i == 800));
        end

        repeat (2) @(posedge clk);
        rst_n = 1'b1;

        wait (operand_q.size() == 0 && !in_ch.valid);
        wait (answer_q.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
sv/mi_pkg.sv
sv/mi_in_if.sv
sv/mi_out_if.sv
sv/mi_datapath.sv
sv/mi_controller.sv
sv/modular_inverse.sv
sv/mi_checker.sv
sim/testbench.sv
